// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the palette block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define PCFI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PCFI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCFI_ASSERT(lbl, clk, rstn, prop, msg)

`define PCFI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/pcfi_pkg.sv -----
package pcfi_pkg;

    localparam int PAL_ENTRIES_DEFAULT = 256;

    localparam int COLOUR_W = 24;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 9;
    localparam int S_TDATA_W = COLOUR_W;
    localparam int M_TDATA_W = 24;

    typedef enum logic {
        OP_FIND  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_FOUND   = 2'd0,
        RES_ADDED   = 2'd1,
        RES_FULL    = 2'd2,
        RES_CLEARED = 2'd3
    } res_code_t;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      commit;
        res_code_t code;
    } pcfi_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic match;
        logic scan_done;
        logic full;
        logic out_free;
    } pcfi_sts_t;

endpackage

// ----- hdl/pcfi_ctrl.sv -----
`include "assert_macros.svh"

module pcfi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  pcfi_pkg::pcfi_sts_t sts,
    output pcfi_pkg::pcfi_cmd_t cmd
);
    import pcfi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   decided;

    always_comb begin
        decided    = sts.op_clear || sts.match || sts.scan_done;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        cmd.code   = RES_FULL;
        state_next = state_reg;
        s_tready   = 1'b0;

        if (sts.op_clear) begin
            cmd.code = RES_CLEARED;
        end else if (sts.match) begin
            cmd.code = RES_FOUND;
        end else if (sts.full) begin
            cmd.code = RES_FULL;
        end else begin
            cmd.code = RES_ADDED;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = !decided;
                if (decided && sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PCFI_ASSERT(a_commit_needs_room, aclk, aresetn, cmd.commit |-> sts.out_free, "result lost")
    `PCFI_ASSERT(a_load_starts_scan, aclk, aresetn, cmd.load |=> (state_reg == S_SCAN), "no scan after load")
    `PCFI_ASSERT(a_no_scan_and_commit, aclk, aresetn, !(cmd.scan && cmd.commit), "scan during commit")

endmodule

// ----- hdl/pcfi_datapath.sv -----
`include "assert_macros.svh"

module pcfi_datapath #(
    parameter int PALETTE_ENTRIES = pcfi_pkg::PAL_ENTRIES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pcfi_pkg::pcfi_cmd_t               cmd,
    output pcfi_pkg::pcfi_sts_t               sts,
    input  logic                              s_op,
    input  logic [pcfi_pkg::COLOUR_W-1:0]     s_colour,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcfi_pkg::INDEX_W-1:0]      m_index,
    output logic [pcfi_pkg::STATUS_W-1:0]     m_status,
    output logic [pcfi_pkg::USED_W-1:0]       m_used
);
    import pcfi_pkg::*;

    localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(PALETTE_ENTRIES);

    logic [COLOUR_W-1:0] mem [PALETTE_ENTRIES];

    logic                op_reg;
    logic [COLOUR_W-1:0] rgb_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic                cmp_vld_reg;
    logic [COLOUR_W-1:0] rd_data_reg;
    logic                rd_en;

    logic                m_tvalid_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [USED_W-1:0]   m_used_reg;

    logic [IW-1:0]       res_index;
    logic [CW-1:0]       res_used;

    assign rd_en = cmd.scan && (scan_idx_reg < count_reg);

    assign sts.op_clear  = (op_reg == OP_CLEAR);
    assign sts.match     = cmp_vld_reg && (rd_data_reg == rgb_reg);
    assign sts.scan_done = !cmp_vld_reg && (scan_idx_reg >= count_reg);
    assign sts.full      = (count_reg == FULL_COUNT);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        res_index = '0;
        res_used  = count_reg;
        case (cmd.code)
            RES_FOUND: begin
                res_index = cmp_idx_reg;
            end
            RES_ADDED: begin
                res_index = count_reg[IW-1:0];
                res_used  = count_reg + CW'(1);
            end
            RES_CLEARED: begin
                res_used = '0;
            end
            default: begin
                res_used = count_reg;
            end
        endcase
    end

    // palette store
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[scan_idx_reg[IW-1:0]];
        end
        if (cmd.commit && (cmd.code == RES_ADDED)) begin
            mem[count_reg[IW-1:0]] <= rgb_reg;
        end
    end

    // item and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_op;
            rgb_reg      <= s_colour;
            scan_idx_reg <= '0;
        end else if (rd_en) begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
            cmp_idx_reg  <= scan_idx_reg[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (cmd.load) begin
                cmp_vld_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= rd_en;
            end
            if (cmd.commit) begin
                count_reg <= res_used;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_index_reg  <= INDEX_W'(res_index);
            m_status_reg <= cmd.code;
            m_used_reg   <= USED_W'(res_used);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_index  = m_index_reg;
    assign m_status = m_status_reg;
    assign m_used   = m_used_reg;

    `PCFI_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL_COUNT, "count beyond palette")
    `PCFI_ASSERT(a_add_has_room, aclk, aresetn, (cmd.commit && cmd.code == RES_ADDED) |-> !sts.full, "append into full palette")
    `PCFI_ASSERT(a_clear_empties, aclk, aresetn, (cmd.commit && cmd.code == RES_CLEARED) |=> (count_reg == '0), "clear left entries")

endmodule

// ----- hdl/palette_color_find_or_insert_unit.sv -----
// channel   | direction | tdata                                         | tuser
// s_*       | in        | red, green, blue                              | operation
// m_*       | out       | index, entries_used                           | status
//
// find: on an empty palette the result is decided without a read, else one stored entry is read per cycle
// clear: decided without a scan; the next item is taken in the cycle after the result is loaded
// the palette scan is the limit: one stored entry compared per cycle
// reset clears the entry count and handshake state; the palette store is not cleared
// a stalled result register holds the decided item, and so the input, until it can take the result

`include "assert_macros.svh"

module palette_color_find_or_insert_unit #(
    parameter int PALETTE_ENTRIES = pcfi_pkg::PAL_ENTRIES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcfi_pkg::S_TDATA_W-1:0]  s_tdata,  // red, green, blue
    input  logic                            s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcfi_pkg::M_TDATA_W-1:0]  m_tdata,  // index, entries_used, zero fill
    output logic [pcfi_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import pcfi_pkg::*;

    pcfi_cmd_t           cmd;
    pcfi_sts_t           sts;
    logic [COLOUR_W-1:0] colour;
    logic [INDEX_W-1:0]  res_index;
    logic [USED_W-1:0]   res_used;

    // colour packed as red in the top byte
    assign colour = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    pcfi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcfi_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_op     (s_tuser),
        .s_colour (colour),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_index  (res_index),
        .m_status (m_tuser),
        .m_used   (res_used)
    );

    assign m_tdata = {{(M_TDATA_W - INDEX_W - USED_W){1'b0}}, res_used, res_index};

    `PCFI_ASSERT(a_no_accept_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second transaction accepted mid scan")
    `PCFI_ASSERT(a_clear_result_zero, aclk, aresetn, (m_tvalid && m_tuser == RES_CLEARED) |-> (m_tdata == '0), "clear result not zero")
    `PCFI_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import pcfi_pkg::*;

    localparam int ENTRIES     = PAL_ENTRIES_DEFAULT;
    localparam int ITEM_TARGET = 1764;
    localparam int CALM_TAIL   = 120;
    localparam int HOLD_LEN    = 800;
    localparam int SETTLE      = 300;
    localparam int CYCLE_LIMIT = 3000000;

    // colour packed as on s_tdata: red in the low byte, blue in the high byte
    typedef struct {
        op_t         op;
        logic [23:0] rgb;
        bit          drain;
    } palette_req_t;

    typedef struct {
        logic [7:0] index;
        res_code_t  status;
        logic [8:0] used;
    } palette_res_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // red, green, blue
    logic                   s_tuser  = 1'b0;  // operation
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // index, entries_used, zero fill
    logic [STATUS_W-1:0]    m_tuser;  // status

    palette_req_t pending_reqs[$];
    palette_res_t expected_res[$];
    logic [23:0]  gen_pal[$];

    logic [23:0]  pal_store [ENTRIES];
    int           pal_used = 0;

    int  items_total    = ITEM_TARGET;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  s_took         = 1'b0;
    int  s_gap          = 0;
    int  r_gap          = 0;
    int  hold_left      = 0;
    int  hold_mark      = -1;
    int  cycle_count;

    palette_color_find_or_insert_unit #(
        .PALETTE_ENTRIES (ENTRIES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial forever #4 aclk = ~aclk;

    function automatic palette_res_t predict_palette(op_t op, logic [23:0] rgb);
        palette_res_t r;
        bit           hit;
        r.index  = '0;
        r.status = RES_CLEARED;
        r.used   = '0;
        if (op == OP_CLEAR) begin
            pal_used = 0;
            return r;
        end
        hit = 1'b0;
        for (int i = 0; i < pal_used && !hit; i++) begin
            if (pal_store[i] == rgb) begin
                hit      = 1'b1;
                r.index  = i[7:0];
                r.status = RES_FOUND;
            end
        end
        if (!hit) begin
            if (pal_used >= ENTRIES) begin
                r.status = RES_FULL;
            end else begin
                pal_store[pal_used] = rgb;
                r.index  = pal_used[7:0];
                r.status = RES_ADDED;
                pal_used++;
            end
        end
        r.used = pal_used[8:0];
        return r;
    endfunction

    function automatic bit gen_known(logic [23:0] rgb);
        foreach (gen_pal[i]) begin
            if (gen_pal[i] == rgb) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic queue_req(op_t op, logic [23:0] rgb, bit drain);
        palette_req_t q;
        q.op    = op;
        q.rgb   = rgb;
        q.drain = drain;
        pending_reqs.push_back(q);
        if (op == OP_CLEAR)
            gen_pal.delete();
        else if (gen_pal.size() < ENTRIES && !gen_known(rgb))
            gen_pal.push_back(rgb);
    endtask

    // every round opens with a clear, then a mix of repeats, near misses, new colours and occasional clears
    task automatic queue_round(int len, int pct_new, bit drain);
        int          k;
        logic [23:0] c;
        logic [31:0] rnd;
        rnd = $urandom();
        queue_req(OP_CLEAR, rnd[23:0], drain);
        for (int n = 0; n < len; n++) begin
            k   = $urandom_range(0, 99);
            rnd = $urandom();
            if (k < 2 && pct_new < 60) begin
                queue_req(OP_CLEAR, rnd[23:0], 1'b0);
            end else if (gen_pal.size() == 0 || k >= 100 - pct_new) begin
                queue_req(OP_FIND, rnd[23:0], 1'b0);
            end else if (k < 12) begin
                c = gen_pal[$urandom_range(0, gen_pal.size() - 1)];
                queue_req(OP_FIND, c ^ (24'd1 << $urandom_range(0, 23)), 1'b0);
            end else begin
                queue_req(OP_FIND, gen_pal[$urandom_range(0, gen_pal.size() - 1)], 1'b0);
            end
        end
    endtask

    initial begin
        int round_no;
        queue_req(OP_CLEAR, 24'h000000, 1'b0);
        queue_req(OP_FIND,  24'h000000, 1'b0);
        queue_req(OP_FIND,  24'hffffff, 1'b0);
        queue_req(OP_FIND,  24'h000000, 1'b0);
        queue_req(OP_FIND,  24'h0000ff, 1'b0);
        queue_req(OP_FIND,  24'h00ff00, 1'b0);
        queue_req(OP_FIND,  24'hff0000, 1'b0);
        queue_req(OP_FIND,  24'hffffff, 1'b0);
        queue_req(OP_FIND,  24'hfffffe, 1'b0);
        queue_req(OP_FIND,  24'h7fffff, 1'b0);
        queue_req(OP_CLEAR, 24'hffffff, 1'b0);
        queue_req(OP_FIND,  24'hffffff, 1'b0);
        queue_req(OP_FIND,  24'h000000, 1'b0);
        queue_req(OP_CLEAR, 24'h5a5a5a, 1'b0);
        queue_req(OP_FIND,  24'h5a5a5a, 1'b1);
        round_no = 0;
        while (pending_reqs.size() < ITEM_TARGET) begin
            if (round_no % 4 == 1)
                queue_round(450, 70, 1'b0);
            else
                queue_round($urandom_range(10, 120), 40, round_no % 3 == 2);
            round_no++;
        end
        while (pending_reqs.size() > ITEM_TARGET) void'(pending_reqs.pop_back());
        items_total = pending_reqs.size();

        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (items_accepted < items_total) @(posedge aclk);
        while (expected_res.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatch_count == 0 && expected_res.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // prediction on input transactions, checking on output transactions
    always @(posedge aclk) begin
        palette_res_t want;
        if (!aresetn) begin
            s_took = 1'b0;
        end else begin
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                expected_res.push_back(predict_palette(op_t'(s_tuser), s_tdata));
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_res.size() == 0) begin
                    $error("unexpected result: index %0d status %0d entries_used %0d",
                           m_tdata[7:0], m_tuser, m_tdata[16:8]);
                    mismatch_count++;
                end else begin
                    want = expected_res.pop_front();
                    if (m_tdata[7:0] !== want.index) begin
                        $error("index: expected %0d, actual %0d", want.index, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[16:8] !== want.used) begin
                        $error("entries_used: expected %0d, actual %0d",
                               want.used, m_tdata[16:8]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        palette_req_t q;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_reqs[0].drain && expected_res.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                q = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= q.rgb;
                s_tuser  <= q.op;
                if (items_total - items_accepted > CALM_TAIL && $urandom_range(0, 5) == 0)
                    s_gap = $urandom_range(1, 19);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // long hold-off so the block backs up and stalls its input
            if ((results_seen == 40 || results_seen == 1000) && hold_mark != results_seen) begin
                hold_mark = results_seen;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (r_gap > 0) begin
                r_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (items_total - items_accepted > CALM_TAIL && $urandom_range(0, 7) == 0)
                    r_gap = $urandom_range(1, 19);
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pcfi_pkg.sv
hdl/pcfi_ctrl.sv
hdl/pcfi_datapath.sv
hdl/palette_color_find_or_insert_unit.sv
test/tb_top.sv
